// ===== design/sprite_bitmap_span_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite bitmap span decoder assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPRITE_BITMAP_SPAN_DECODER_ASSERT_SVH
`define SPRITE_BITMAP_SPAN_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of aclk, masked while reset is asserted.
`define SBSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every rising edge of aclk, including during reset.
`define SBSD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SBSD_ASSERT(label, prop, msg)
`define SBSD_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== design/sbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite bitmap span decoder package
// Limits, field widths, register indexes, mode and header phase codes.
// ----------------------------------------------------------------------------
package sbsd_pkg;

    // Dimension limits: width and height saturate at MAX_DIM, stride at MAX_STRIDE.
    localparam int MAX_DIM    = 1024;
    localparam int MAX_STRIDE = 2048;

    // Field widths.
    localparam int DIM_W    = 11;
    localparam int STRIDE_W = 12;
    localparam int ADDR_W   = 20;
    localparam int BYTE_W   = 8;
    localparam int SPAN_W   = 16;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODING_MODE = 2'd3;

    // Encoding modes.
    localparam logic [1:0] MODE_SPAN    = 2'd0;
    localparam logic [1:0] MODE_RAW_ROW = 2'd1;
    localparam logic [1:0] MODE_RAW_COL = 2'd2;

    // Span header phases; PH_PIXELS means pixel bytes follow.
    localparam logic [PHASE_W-1:0] PH_START_HI = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START_LO = 3'd1;
    localparam logic [PHASE_W-1:0] PH_END_HI   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_END_LO   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PIXELS   = 3'd4;

    // One result word.
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] pixel_address;
        logic [BYTE_W-1:0] pixel_value;
        logic              image_done;
        logic              span_error;
    } result_t;

endpackage

// ===== design/sprite_bitmap_span_decoder.sv =====
// ----------------------------------------------------------------------------
// Sprite bitmap span decoder
// Turns a sprite pixel-data byte stream into row-major frame-buffer writes.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while m_ready does not stall it and
// returns one result word per byte: the byte lands in an input register, then
// a single pass through the counter update, the span header checks and one
// 12 x 11 bit address multiply-add fills the result register. Both registers
// are elastic, so a new byte is taken while a finished word still waits for
// m_ready. The rate is set by that single pass, which holds all decoder state
// and updates it once per byte. Configuration is written through the cfg_
// channel, which is always ready, and must only change while the block is idle.
`include "sprite_bitmap_span_decoder_assert.svh"

module sprite_bitmap_span_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Byte input channel.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sbsd_pkg::BYTE_W-1:0]      s_data_byte,
    input  logic                             s_first_byte,
    // Result channel.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_write_valid,
    output logic [sbsd_pkg::ADDR_W-1:0]      m_pixel_address,
    output logic [sbsd_pkg::BYTE_W-1:0]      m_pixel_value,
    output logic                             m_image_done,
    output logic                             m_span_error
);
    import sbsd_pkg::*;

    localparam int MUL_W = STRIDE_W + DIM_W;

    // Configuration registers.
    logic [DIM_W-1:0]    img_width_reg;
    logic [DIM_W-1:0]    img_height_reg;
    logic [STRIDE_W-1:0] row_stride_reg;
    logic [1:0]          encoding_mode_reg;

    // Decoder state.
    logic [DIM_W-1:0]    column_index_reg, column_index_next;
    logic [DIM_W-1:0]    row_index_reg, row_index_next;
    logic [STRIDE_W-1:0] line_offset_reg, line_offset_next;
    logic [PHASE_W-1:0]  header_phase_reg, header_phase_next;
    logic [SPAN_W-1:0]   span_start_reg, span_start_next;
    logic [SPAN_W-1:0]   span_end_reg, span_end_next;
    logic                finished_reg, finished_next;

    // Pipeline registers.
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_first_reg;
    logic                out_valid_reg;
    result_t             result_reg, result_next;

    logic advance;
    logic proc;

    // Values after a first-byte restart.
    logic [DIM_W-1:0]    cur_col;
    logic [DIM_W-1:0]    cur_row;
    logic [STRIDE_W-1:0] cur_off;
    logic [PHASE_W-1:0]  cur_phase;
    logic [SPAN_W-1:0]   cur_start;
    logic [SPAN_W-1:0]   cur_end;
    logic                cur_fin;

    // Clamped dimensions and line lengths.
    logic [DIM_W-1:0]    dim_w;
    logic [DIM_W-1:0]    dim_h;
    logic [STRIDE_W-1:0] stride_s;
    logic [STRIDE_W-1:0] len_row;
    logic [STRIDE_W-1:0] len_col;

    // Shared counters, compares and address arithmetic.
    logic [DIM_W-1:0]    col_inc;
    logic                col_last;
    logic [DIM_W-1:0]    row_inc;
    logic [STRIDE_W:0]   off_inc;
    logic [SPAN_W-1:0]   end_full;
    logic [STRIDE_W-1:0] mul_a;
    logic [STRIDE_W-1:0] add_term;
    logic [MUL_W-1:0]    product;
    logic [MUL_W:0]      addr_sum;
    logic                done;

    // Handshakes.
    assign advance   = !out_valid_reg || m_ready;
    assign proc      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Restart all counters ahead of a byte flagged as the first of a bitmap.
    assign cur_col   = in_first_reg ? '0 : column_index_reg;
    assign cur_row   = in_first_reg ? '0 : row_index_reg;
    assign cur_off   = in_first_reg ? '0 : line_offset_reg;
    assign cur_phase = in_first_reg ? PH_START_HI : header_phase_reg;
    assign cur_start = in_first_reg ? '0 : span_start_reg;
    assign cur_end   = in_first_reg ? '0 : span_end_reg;
    assign cur_fin   = in_first_reg ? 1'b0 : finished_reg;

    // Saturate the dimensions and derive the raw line lengths.
    assign dim_w = (int'(img_width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : img_width_reg;
    assign dim_h = (int'(img_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : img_height_reg;
    assign stride_s = (int'(row_stride_reg) > MAX_STRIDE) ? STRIDE_W'(MAX_STRIDE)
                                                          : row_stride_reg;
    assign len_row = (stride_s > {1'b0, dim_w}) ? stride_s : {1'b0, dim_w};
    assign len_col = (stride_s > {1'b0, dim_h}) ? stride_s : {1'b0, dim_h};

    assign col_inc  = cur_col + 1'b1;
    assign col_last = (col_inc >= dim_w);
    assign row_inc  = cur_row + 1'b1;
    assign off_inc  = {1'b0, cur_off} + 1'b1;
    assign end_full = cur_end | {{(SPAN_W-BYTE_W){1'b0}}, in_byte_reg};

    // One multiply-add serves all modes: row index times width plus column index.
    always_comb begin
        case (encoding_mode_reg)
            MODE_RAW_ROW: begin
                mul_a    = {1'b0, cur_row};
                add_term = cur_off;
            end
            MODE_RAW_COL: begin
                mul_a    = cur_off;
                add_term = {1'b0, cur_col};
            end
            default: begin
                mul_a    = {1'b0, cur_row};
                add_term = {1'b0, cur_col};
            end
        endcase
    end

    assign product  = mul_a * dim_w;
    assign addr_sum = {1'b0, product} + {{(MUL_W-STRIDE_W+1){1'b0}}, add_term};

    // Decode one byte: result word and next decoder state.
    always_comb begin
        column_index_next = cur_col;
        row_index_next    = cur_row;
        line_offset_next  = cur_off;
        header_phase_next = cur_phase;
        span_start_next   = cur_start;
        span_end_next     = cur_end;
        result_next       = '0;
        done              = 1'b0;

        if (!cur_fin) begin
            case (encoding_mode_reg)
                MODE_SPAN: begin
                    if (cur_col >= dim_w) begin
                        done = 1'b1;
                    end else begin
                        case (cur_phase)
                            PH_START_HI: begin
                                span_start_next   = {in_byte_reg, 8'h00};
                                header_phase_next = PH_START_LO;
                            end
                            PH_START_LO: begin
                                span_start_next = cur_start |
                                    {{(SPAN_W-BYTE_W){1'b0}}, in_byte_reg};
                                header_phase_next = PH_END_HI;
                            end
                            PH_END_HI: begin
                                span_end_next     = {in_byte_reg, 8'h00};
                                header_phase_next = PH_END_LO;
                            end
                            PH_END_LO: begin
                                span_end_next = end_full;
                                if (end_full < cur_start ||
                                    end_full > {{(SPAN_W-DIM_W){1'b0}}, dim_h}) begin
                                    // Inverted or oversized span: skip the column.
                                    result_next.span_error = 1'b1;
                                    column_index_next      = col_inc;
                                    header_phase_next      = PH_START_HI;
                                    done                   = col_last;
                                end else if (end_full == cur_start) begin
                                    // Empty span: straight on to the next column.
                                    column_index_next = col_inc;
                                    header_phase_next = PH_START_HI;
                                    done              = col_last;
                                end else begin
                                    row_index_next    = cur_start[DIM_W-1:0];
                                    header_phase_next = PH_PIXELS;
                                end
                            end
                            default: begin
                                // Pixel byte written down the column.
                                result_next.write_valid   = 1'b1;
                                result_next.pixel_value   = in_byte_reg;
                                result_next.pixel_address = addr_sum[ADDR_W-1:0];
                                row_index_next            = row_inc;
                                if ({{(SPAN_W-DIM_W){1'b0}}, row_inc} >= cur_end) begin
                                    column_index_next = col_inc;
                                    header_phase_next = PH_START_HI;
                                    done              = col_last;
                                end
                            end
                        endcase
                    end
                end
                MODE_RAW_ROW: begin
                    if (dim_w == '0 || cur_row >= dim_h) begin
                        done = 1'b1;
                    end else begin
                        if (cur_off < {1'b0, dim_w}) begin
                            result_next.write_valid   = 1'b1;
                            result_next.pixel_value   = in_byte_reg;
                            result_next.pixel_address = addr_sum[ADDR_W-1:0];
                            done = (cur_row == dim_h - 1'b1) &&
                                   (cur_off == {1'b0, dim_w - 1'b1});
                        end
                        // Padding bytes only advance the line position.
                        if (off_inc >= {1'b0, len_row}) begin
                            line_offset_next = '0;
                            row_index_next   = row_inc;
                        end else begin
                            line_offset_next = off_inc[STRIDE_W-1:0];
                        end
                    end
                end
                MODE_RAW_COL: begin
                    if (dim_h == '0 || cur_col >= dim_w) begin
                        done = 1'b1;
                    end else begin
                        if (cur_off < {1'b0, dim_h}) begin
                            result_next.write_valid   = 1'b1;
                            result_next.pixel_value   = in_byte_reg;
                            result_next.pixel_address = addr_sum[ADDR_W-1:0];
                            done = (cur_col == dim_w - 1'b1) &&
                                   (cur_off == {1'b0, dim_h - 1'b1});
                        end
                        if (off_inc >= {1'b0, len_col}) begin
                            line_offset_next  = '0;
                            column_index_next = col_inc;
                        end else begin
                            line_offset_next = off_inc[STRIDE_W-1:0];
                        end
                    end
                end
                default: begin
                    // Unused mode writes nothing and never completes.
                end
            endcase
        end

        result_next.image_done = done;
        finished_next          = cur_fin | done;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg     <= '0;
            img_height_reg    <= '0;
            row_stride_reg    <= '0;
            encoding_mode_reg <= MODE_SPAN;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMG_WIDTH:     img_width_reg     <= cfg_data[DIM_W-1:0];
                CFG_IMG_HEIGHT:    img_height_reg    <= cfg_data[DIM_W-1:0];
                CFG_ROW_STRIDE:    row_stride_reg    <= cfg_data[STRIDE_W-1:0];
                CFG_ENCODING_MODE: encoding_mode_reg <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Decoder state, updated once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg <= '0;
            row_index_reg    <= '0;
            line_offset_reg  <= '0;
            header_phase_reg <= PH_START_HI;
            span_start_reg   <= '0;
            span_end_reg     <= '0;
            finished_reg     <= 1'b0;
        end else if (proc) begin
            column_index_reg <= column_index_next;
            row_index_reg    <= row_index_next;
            line_offset_reg  <= line_offset_next;
            header_phase_reg <= header_phase_next;
            span_start_reg   <= span_start_next;
            span_end_reg     <= span_end_next;
            finished_reg     <= finished_next;
        end
    end

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (proc) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_valid   = result_reg.write_valid;
    assign m_pixel_address = result_reg.pixel_address;
    assign m_pixel_value   = result_reg.pixel_value;
    assign m_image_done    = result_reg.image_done;
    assign m_span_error    = result_reg.span_error;

    // Reset empties the result register.
    `SBSD_ASSERT_RST(a_reset_empties_output, !aresetn |=> !m_valid, "result valid after reset")
    // A held byte is not lost while the result side stalls.
    `SBSD_ASSERT(a_input_held, in_valid_reg && !advance |=> in_valid_reg, "stalled byte dropped")
    // A byte that completes the bitmap leaves the decoder finished.
    `SBSD_ASSERT(a_done_sets_finished, proc && done |=> finished_reg, "image_done not latched")
    // Span errors only come from span mode and never carry a write.
    `SBSD_ASSERT(a_error_in_span_mode,
        m_valid && m_span_error |-> encoding_mode_reg == MODE_SPAN && !m_write_valid,
        "span error outside span mode")

endmodule

// ===== tb/sv/sprite_bitmap_span_decoder_test.sv =====
// ----------------------------------------------------------------------------
// Sprite bitmap span decoder testbench
// Drives pixel-data bytes through the decoder in all encoding modes, predicts
// every result word with a cycle-free decoder model or a directed value, and checks each word.
// ----------------------------------------------------------------------------
module sprite_bitmap_span_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbsd_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int ITEM_TARGET  = 1800;
    localparam int QUIET_ITEMS  = 250;
    localparam int LONG_HOLD    = 300;
    localparam int BITMAP_CAP   = 160;
    localparam int SETTLE_CYCLES = 8;

    localparam result_t IDLE_WORD = '0;
    localparam result_t DONE_WORD = result_t'{1'b0, 20'd0, 8'd0, 1'b1, 1'b0};
    localparam result_t BAD_SPAN_WORD = result_t'{1'b0, 20'd0, 8'd0, 1'b0, 1'b1};

    // One byte of the stream with its restart flag.
    typedef struct packed {
        logic       restart;
        logic [7:0] value;
    } stream_word_t;

    // One row of the directed plan: a register write or a byte.
    typedef struct {
        bit          is_reg;
        logic [1:0]  reg_index;
        logic [11:0] reg_value;
        logic [7:0]  value;
        logic        restart;
        bit          typed;
        result_t     want;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn         = 1'b0;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte     = '0;
    logic                  s_first_byte    = 1'b0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic                  m_write_valid;
    logic [ADDR_W-1:0]     m_pixel_address;
    logic [BYTE_W-1:0]     m_pixel_value;
    logic                  m_image_done;
    logic                  m_span_error;

    // Decoder model state and its register copy.
    logic [10:0] col_idx        = '0;
    logic [10:0] row_idx        = '0;
    logic [11:0] line_pos       = '0;
    logic [2:0]  hdr_phase      = PH_START_HI;
    logic [15:0] span_first     = '0;
    logic [15:0] span_last      = '0;
    logic        image_finished = 1'b0;
    logic [10:0] cfg_width      = '0;
    logic [10:0] cfg_height     = '0;
    logic [11:0] cfg_stride     = '0;
    logic [1:0]  cfg_mode       = MODE_SPAN;

    result_t      due_words[$];
    stream_word_t stream_q[$];
    plan_row_t    plan[$];

    // Typed expectation that rides along with the byte on s_.
    bit      check_typed  = 1'b0;
    result_t typed_result = '0;

    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  items_sent   = 0;
    bit  quiet_tail   = 1'b0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;
    bit  hold_req     = 1'b0;

    sprite_bitmap_span_decoder u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_first_byte    (s_first_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_valid   (m_write_valid),
        .m_pixel_address (m_pixel_address),
        .m_pixel_value   (m_pixel_value),
        .m_image_done    (m_image_done),
        .m_span_error    (m_span_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Step to the next span column; reports whether the bitmap is complete.
    function automatic logic next_column(int unsigned w);
        col_idx   = col_idx + 11'd1;
        hdr_phase = PH_START_HI;
        return col_idx >= w;
    endfunction

    // Decode one byte against the model state and return its result word.
    function automatic result_t decode_byte(logic [7:0] b, logic restart);
        int unsigned w, h, s, len;
        result_t r;
        w = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
        h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        s = (cfg_stride > MAX_STRIDE) ? MAX_STRIDE : cfg_stride;
        r = '0;
        if (restart) begin
            col_idx        = '0;
            row_idx        = '0;
            line_pos       = '0;
            hdr_phase      = PH_START_HI;
            span_first     = '0;
            span_last      = '0;
            image_finished = 1'b0;
        end
        if (!image_finished) begin
            case (cfg_mode)
                MODE_SPAN: begin
                    if (col_idx >= w) begin
                        r.image_done = 1'b1;
                    end else if (hdr_phase != PH_PIXELS) begin
                        case (hdr_phase)
                            PH_START_HI: span_first = {b, 8'h00};
                            PH_START_LO: span_first[7:0] = b;
                            PH_END_HI:   span_last = {b, 8'h00};
                            default:     span_last[7:0] = b;
                        endcase
                        if (hdr_phase != PH_END_LO) begin
                            hdr_phase = hdr_phase + 3'd1;
                        end else if (span_last < span_first || span_last > h) begin
                            r.span_error = 1'b1;
                            r.image_done = next_column(w);
                        end else if (span_last == span_first) begin
                            r.image_done = next_column(w);
                        end else begin
                            row_idx   = span_first[10:0];
                            hdr_phase = PH_PIXELS;
                        end
                    end else begin
                        r.write_valid   = 1'b1;
                        r.pixel_value   = b;
                        r.pixel_address = ADDR_W'(row_idx * w + col_idx);
                        row_idx = row_idx + 11'd1;
                        if (row_idx >= span_last)
                            r.image_done = next_column(w);
                    end
                end
                MODE_RAW_ROW: begin
                    len = (s > w) ? s : w;
                    if (w == 0 || row_idx >= h) begin
                        r.image_done = 1'b1;
                    end else begin
                        if (line_pos < w) begin
                            r.write_valid   = 1'b1;
                            r.pixel_value   = b;
                            r.pixel_address = ADDR_W'(row_idx * w + line_pos);
                            r.image_done    = (row_idx == h - 1 && line_pos == w - 1);
                        end
                        line_pos = line_pos + 12'd1;
                        if (line_pos >= len) begin
                            line_pos = '0;
                            row_idx  = row_idx + 11'd1;
                        end
                    end
                end
                MODE_RAW_COL: begin
                    len = (s > h) ? s : h;
                    if (h == 0 || col_idx >= w) begin
                        r.image_done = 1'b1;
                    end else begin
                        // Column-order bytes are transposed into row-major addresses.
                        if (line_pos < h) begin
                            r.write_valid   = 1'b1;
                            r.pixel_value   = b;
                            r.pixel_address = ADDR_W'(line_pos * w + col_idx);
                            r.image_done    = (col_idx == w - 1 && line_pos == h - 1);
                        end
                        line_pos = line_pos + 12'd1;
                        if (line_pos >= len) begin
                            line_pos = '0;
                            col_idx  = col_idx + 11'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (r.image_done)
            image_finished = 1'b1;
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Accepted words on all three channels, sampled at the rising edge.
    always @(posedge aclk) begin : monitor
        result_t got, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMG_WIDTH:     cfg_width  = cfg_data[10:0];
                    CFG_IMG_HEIGHT:    cfg_height = cfg_data[10:0];
                    CFG_ROW_STRIDE:    cfg_stride = cfg_data;
                    CFG_ENCODING_MODE: cfg_mode   = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = decode_byte(s_data_byte, s_first_byte);
                due_words.push_back(check_typed ? typed_result : want);
            end
            if (m_valid && m_ready) begin
                got = {m_write_valid, m_pixel_address, m_pixel_value,
                       m_image_done, m_span_error};
                if (due_words.size() == 0) begin
                    note_failure("result word arrived with no byte outstanding");
                end else begin
                    want = due_words.pop_front();
                    if (got.write_valid !== want.write_valid ||
                        got.pixel_address !== want.pixel_address ||
                        got.pixel_value !== want.pixel_value ||
                        got.image_done !== want.image_done ||
                        got.span_error !== want.span_error)
                        note_failure($sformatf({"word mismatch: expected wv=%0b addr=%05h ",
                            "val=%02h done=%0b err=%0b, got wv=%0b addr=%05h val=%02h ",
                            "done=%0b err=%0b"},
                            want.write_valid, want.pixel_address, want.pixel_value,
                            want.image_done, want.span_error,
                            got.write_valid, got.pixel_address, got.pixel_value,
                            got.image_done, got.span_error));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall bursts plus one long hold on request.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && sink_idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the decoder takes it.
    task automatic send_byte(logic [7:0] value, logic restart, bit typed, result_t want);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_data_byte  <= value;
        s_first_byte <= restart;
        check_typed  <= typed;
        typed_result <= want;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Occasional random gap, with s_valid low, before the next byte.
    task automatic maybe_gap();
        int n;
        if (!quiet_tail && src_idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 18);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Stop offering and wait until every outstanding word has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [11:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned s,
                             logic [11:0] mode_word);
        drain();
        write_reg(CFG_IMG_WIDTH, 12'(w));
        write_reg(CFG_IMG_HEIGHT, 12'(h));
        write_reg(CFG_ROW_STRIDE, 12'(s));
        write_reg(CFG_ENCODING_MODE, mode_word);
    endtask

    function automatic void add_reg(logic [1:0] index, logic [11:0] value);
        plan_row_t r;
        r = '{default: '0};
        r.is_reg    = 1'b1;
        r.reg_index = index;
        r.reg_value = value;
        plan.push_back(r);
    endfunction

    function automatic void add_byte(logic [7:0] value, logic restart);
        plan_row_t r;
        r = '{default: '0};
        r.value   = value;
        r.restart = restart;
        plan.push_back(r);
    endfunction

    function automatic void add_check(logic [7:0] value, logic restart, result_t want);
        plan_row_t r;
        r = '{default: '0};
        r.value   = value;
        r.restart = restart;
        r.typed   = 1'b1;
        r.want    = want;
        plan.push_back(r);
    endfunction

    function automatic void push_byte(int unsigned value);
        stream_q.push_back(stream_word_t'{1'b0, 8'(value)});
    endfunction

    function automatic int unsigned pick_dim();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 0;
        if (k == 1)
            return $urandom_range(1000, 4095);
        return $urandom_range(1, 12);
    endfunction

    // Append one bitmap for the current settings, cut at cap bytes.
    function automatic void build_bitmap(int unsigned cap, logic restart);
        int unsigned w, h, s, n, a, e, k, c, base;
        base = stream_q.size();
        w = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
        h = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        s = (cfg_stride > MAX_STRIDE) ? MAX_STRIDE : cfg_stride;
        if (cfg_mode == MODE_SPAN) begin
            // Mostly good spans, with inverted, too tall and empty ones mixed in.
            for (c = 0; c < w && stream_q.size() - base < cap; c++) begin
                k = $urandom_range(0, 9);
                if (k == 0 && $urandom_range(0, 1) == 1) begin
                    a = $urandom_range(1, 65535);
                    e = $urandom_range(0, a - 1);
                end else if (k == 0) begin
                    e = $urandom_range(h + 1, 65535);
                    a = $urandom_range(0, e);
                end else if (k == 1 || h == 0) begin
                    a = $urandom_range(0, h);
                    e = a;
                end else begin
                    a = $urandom_range(0, h - 1);
                    e = a + $urandom_range(1, (h - a < 12) ? h - a : 12);
                end
                push_byte(a >> 8);
                push_byte(a);
                push_byte(e >> 8);
                push_byte(e);
                if (k >= 2 && h != 0)
                    repeat (e - a) push_byte($urandom);
            end
            if (stream_q.size() == base)
                push_byte($urandom);
        end else begin
            if (cfg_mode == MODE_RAW_ROW && w != 0 && h != 0)
                n = (h - 1) * ((s > w) ? s : w) + w;
            else if (cfg_mode == MODE_RAW_COL && w != 0 && h != 0)
                n = (w - 1) * ((s > h) ? s : h) + h;
            else
                n = $urandom_range(1, 8);
            if (n > cap)
                n = cap;
            repeat (n) push_byte($urandom);
        end
        // A few bytes past the end of the bitmap.
        repeat ($urandom_range(0, 2)) push_byte($urandom);
        stream_q[base].restart = restart;
    endfunction

    task automatic send_stream();
        stream_word_t word;
        while (stream_q.size() != 0) begin
            word = stream_q.pop_front();
            quiet_tail = (items_sent + QUIET_ITEMS >= ITEM_TARGET);
            maybe_gap();
            send_byte(word.value, word.restart, 1'b0, IDLE_WORD);
            items_sent++;
        end
    endtask

    initial begin : stimulus
        int unsigned w, h, s, k, phase_no, bitmaps;
        logic [1:0]  mode;
        logic [11:0] mode_word;

        // Directed plan. Right after reset the width is zero.
        add_check(8'h00, 1'b0, DONE_WORD);
        add_check(8'hFF, 1'b0, IDLE_WORD);
        // Saturated width, full height: a span ending exactly at the height.
        add_reg(CFG_IMG_WIDTH, 12'd2047);
        add_reg(CFG_IMG_HEIGHT, 12'd1024);
        add_check(8'h03, 1'b1, IDLE_WORD);
        add_check(8'hE8, 1'b0, IDLE_WORD);
        add_check(8'h04, 1'b0, IDLE_WORD);
        add_check(8'h00, 1'b0, IDLE_WORD);
        add_check(8'hFF, 1'b0, result_t'{1'b1, 20'd1024000, 8'hFF, 1'b0, 1'b0});
        add_byte(8'h00, 1'b0);
        // Restart: an inverted span, a span past the height, an empty span.
        add_byte(8'h00, 1'b1);
        add_byte(8'h05, 1'b0);
        add_byte(8'h00, 1'b0);
        add_check(8'h04, 1'b0, BAD_SPAN_WORD);
        add_byte(8'h04, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h04, 1'b0);
        add_check(8'h02, 1'b0, BAD_SPAN_WORD);
        add_byte(8'h00, 1'b0);
        add_byte(8'h07, 1'b0);
        add_byte(8'h00, 1'b0);
        add_check(8'h07, 1'b0, IDLE_WORD);
        // Raw rows, one line of two pixels, saturated stride.
        add_reg(CFG_IMG_WIDTH, 12'd2);
        add_reg(CFG_IMG_HEIGHT, 12'd1);
        add_reg(CFG_ROW_STRIDE, 12'd4095);
        add_reg(CFG_ENCODING_MODE, 12'(MODE_RAW_ROW));
        add_check(8'hAA, 1'b1, result_t'{1'b1, 20'd0, 8'hAA, 1'b0, 1'b0});
        add_check(8'h55, 1'b0, result_t'{1'b1, 20'd1, 8'h55, 1'b1, 1'b0});
        add_check(8'h11, 1'b0, IDLE_WORD);
        // The unused mode writes nothing.
        add_reg(CFG_ENCODING_MODE, 12'(MODE_UNUSED));
        add_check(8'hFF, 1'b1, IDLE_WORD);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                drain();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end else begin
                maybe_gap();
                send_byte(plan[i].value, plan[i].restart, plan[i].typed, plan[i].want);
            end
        end

        // Short stride in raw rows: every line still holds all of its pixels.
        configure(3, 4, 1, 12'(MODE_RAW_ROW));
        build_bitmap(BITMAP_CAP, 1'b1);
        send_stream();

        // Random phases: new settings, then a few bitmaps with some noise.
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            k = $urandom_range(0, 19);
            mode = (k < 8) ? MODE_SPAN : (k < 14) ? MODE_RAW_ROW :
                   (k < 19) ? MODE_RAW_COL : MODE_UNUSED;
            mode_word = ($urandom_range(0, 3) == 0) ?
                        {10'($urandom_range(0, 1023)), mode} : 12'(mode);
            w = pick_dim();
            h = pick_dim();
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(2049, 4095) :
                $urandom_range(0, 16);
            configure(w, h, s, mode_word);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            // One long hold on the result side while bytes keep coming.
            if (phase_no == 3) begin
                src_idle_on = 1'b0;
                hold_req    = 1'b1;
            end
            bitmaps = $urandom_range(1, 4);
            for (int b = 0; b < bitmaps && items_sent < ITEM_TARGET; b++) begin
                // The first bitmap sometimes carries on from the old counters.
                build_bitmap(BITMAP_CAP, !(b == 0 && $urandom_range(0, 3) == 0));
                // Enough bytes behind the long hold to fill the block.
                if (phase_no == 3 && b == 0)
                    repeat (8) push_byte($urandom);
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 12))
                        stream_q.push_back(stream_word_t'{$urandom_range(0, 3) == 0,
                                                          8'($urandom)});
                send_stream();
            end
            phase_no++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
